### src/tpst_pkg.sv
// Shared widths, codes and defaults for the tag presence stability table.
package tpst_pkg;

   localparam int TAG_LOW_W     = 64;
   localparam int TAG_HIGH_W    = 56;
   localparam int TAG_W         = TAG_LOW_W + TAG_HIGH_W;
   localparam int RUN_W         = 8;
   localparam int STABLE_MIN_W  = 8;
   localparam int FACTOR_W      = 3;
   localparam int CSR_DATA_W    = 8;
   localparam int CSR_INDEX_W   = 1;
   localparam int DEFAULT_SLOTS = 32;

   localparam logic [STABLE_MIN_W-1:0] STABLE_MIN_RESET = 8'd10;
   localparam logic [FACTOR_W-1:0]     FACTOR_RESET     = 3'd3;
   localparam logic [RUN_W-1:0]        RUN_MAX          = 8'hFF;

   localparam logic [CSR_INDEX_W-1:0] CSR_STABLE_MIN    = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_STABLE_FACTOR = 1'd1;

   typedef enum logic [1:0] {
      SLOT_FREE = 2'd0,
      SLOT_OLD  = 2'd1,
      SLOT_STAY = 2'd2,
      SLOT_NEW  = 2'd3
   } slot_status_type;

endpackage

### src/tpst_if.sv
// Handshake channels for tag reads and emitted tags.
interface tpst_req_if
   import tpst_pkg::*;
   ();
   logic                  valid;
   logic                  ready;
   logic [TAG_LOW_W-1:0]  tag_low;
   logic [TAG_HIGH_W-1:0] tag_high;

   modport source (output valid, output tag_low, output tag_high, input ready);
   modport sink   (input valid, input tag_low, input tag_high, output ready);
endinterface

interface tpst_rsp_if
   import tpst_pkg::*;
   ();
   logic                  valid;
   logic                  ready;
   logic [TAG_LOW_W-1:0]  out_tag_low;
   logic [TAG_HIGH_W-1:0] out_tag_high;
   logic                  last;

   modport source (output valid, output out_tag_low, output out_tag_high, output last,
                   input ready);
   modport sink   (input valid, input out_tag_low, input out_tag_high, input last,
                   output ready);
endinterface

### src/tag_presence_stability_table_core.sv
// Tag presence stability table: top level with tag memory and sequencer.
//
// Each accepted tag read walks the whole tag memory through its single read
// port, one slot a cycle, comparing against the stored tags, noting the first
// free slot and counting active slots; no new read is accepted until the walk
// and the decision are done. When a stable read pushes the run counter past
// the threshold, the memory is walked again to emit the active tags in slot
// order; each active slot waits for fresh read data and a free result register,
// so a stalled result side holds the walk. The slot status is cleared by reset
// at once; the tag memory needs no clearing since a free slot never matches.
module tag_presence_stability_table_core
   import tpst_pkg::*;
#(
   parameter int TABLE_SLOTS = DEFAULT_SLOTS
) (
   input  logic                   clock,
   input  logic                   reset,
   tpst_req_if.sink               req_ch,
   tpst_rsp_if.source             rsp_ch,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   localparam int IDX_W  = $clog2(TABLE_SLOTS);
   localparam int CNT_W  = $clog2(TABLE_SLOTS + 1);
   localparam int PROD_W = FACTOR_W + CNT_W;
   localparam int THR_W  = (PROD_W > RUN_W) ? PROD_W : RUN_W;
   localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(TABLE_SLOTS - 1);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_DECIDE,
      ST_EMIT
   } state_type;

   state_type                state_ff;
   logic [STABLE_MIN_W-1:0]  stable_min_ff;
   logic [FACTOR_W-1:0]      factor_ff;
   logic [RUN_W-1:0]         run_ff;
   slot_status_type          status_ff [TABLE_SLOTS];
   logic [TAG_W-1:0]         tag_ff;
   logic [IDX_W-1:0]         slot_ff;
   logic                     issue_ff;
   logic                     cmp_valid_ff;
   logic [IDX_W-1:0]         cmp_idx_ff;
   logic                     hit_found_ff;
   logic [IDX_W-1:0]         hit_idx_ff;
   logic                     free_found_ff;
   logic [IDX_W-1:0]         free_idx_ff;
   logic [CNT_W-1:0]         active_ff;
   logic [CNT_W-1:0]         emit_cnt_ff;
   logic                     fresh_ff;
   logic                     rsp_valid_ff;
   logic [TAG_W-1:0]         rsp_tag_ff;
   logic                     rsp_last_ff;

   logic [TAG_W-1:0]         mem [TABLE_SLOTS];
   logic [TAG_W-1:0]         rd_data_ff;
   logic                     mem_we;

   slot_status_type          cmp_status;
   slot_status_type          emit_status;
   logic                     cmp_match;
   logic [PROD_W-1:0]        product;
   logic [THR_W-1:0]         threshold;
   logic [RUN_W-1:0]         run_in;
   logic                     emit_go;
   logic                     rsp_free;
   logic                     emit_active;
   logic                     emit_push;

   assign cmp_status  = status_ff[cmp_idx_ff];
   assign emit_status = status_ff[slot_ff];
   assign cmp_match   = (cmp_status != SLOT_FREE) && (rd_data_ff == tag_ff);

   assign product   = PROD_W'(factor_ff) * PROD_W'(active_ff);
   assign threshold = (THR_W'(product) < THR_W'(stable_min_ff)) ?
                      THR_W'(stable_min_ff) : THR_W'(product);
   assign run_in    = (run_ff == RUN_MAX) ? run_ff : run_ff + RUN_W'(1);
   assign emit_go   = (THR_W'(run_in) > threshold);

   assign rsp_free    = !rsp_valid_ff || rsp_ch.ready;
   assign emit_active = (emit_status == SLOT_STAY) || (emit_status == SLOT_NEW);
   assign emit_push   = (state_ff == ST_EMIT) && emit_active && fresh_ff && rsp_free;
   assign mem_we      = (state_ff == ST_DECIDE) && !hit_found_ff && free_found_ff;

   assign req_ch.ready        = (state_ff == ST_IDLE);
   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.out_tag_low  = rsp_tag_ff[TAG_LOW_W-1:0];
   assign rsp_ch.out_tag_high = rsp_tag_ff[TAG_W-1:TAG_LOW_W];
   assign rsp_ch.last         = rsp_last_ff;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[free_idx_ff] <= tag_ff;
      end
      rd_data_ff <= mem[slot_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         stable_min_ff <= STABLE_MIN_RESET;
         factor_ff     <= FACTOR_RESET;
         run_ff        <= '0;
         for (int i = 0; i < TABLE_SLOTS; i++) begin
            status_ff[i] <= SLOT_FREE;
         end
         tag_ff        <= '0;
         slot_ff       <= '0;
         issue_ff      <= 1'b0;
         cmp_valid_ff  <= 1'b0;
         cmp_idx_ff    <= '0;
         hit_found_ff  <= 1'b0;
         hit_idx_ff    <= '0;
         free_found_ff <= 1'b0;
         free_idx_ff   <= '0;
         active_ff     <= '0;
         emit_cnt_ff   <= '0;
         fresh_ff      <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         rsp_tag_ff    <= '0;
         rsp_last_ff   <= 1'b0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_STABLE_MIN:    stable_min_ff <= csr_wdata[STABLE_MIN_W-1:0];
               CSR_STABLE_FACTOR: factor_ff     <= csr_wdata[FACTOR_W-1:0];
               default: ;
            endcase
         end

         if (emit_push) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end

         cmp_valid_ff <= (state_ff == ST_SEARCH) && issue_ff;
         cmp_idx_ff   <= slot_ff;

         case (state_ff)
            ST_IDLE: begin
               if (req_ch.valid) begin
                  tag_ff        <= {req_ch.tag_high, req_ch.tag_low};
                  slot_ff       <= '0;
                  issue_ff      <= 1'b1;
                  hit_found_ff  <= 1'b0;
                  free_found_ff <= 1'b0;
                  active_ff     <= '0;
                  state_ff      <= ST_SEARCH;
               end
            end

            ST_SEARCH: begin
               if (issue_ff) begin
                  if (slot_ff == LAST_SLOT) begin
                     issue_ff <= 1'b0;
                  end else begin
                     slot_ff <= slot_ff + IDX_W'(1);
                  end
               end
               if (cmp_valid_ff) begin
                  if (cmp_match && !hit_found_ff) begin
                     hit_found_ff <= 1'b1;
                     hit_idx_ff   <= cmp_idx_ff;
                  end
                  if (cmp_status == SLOT_FREE && !free_found_ff) begin
                     free_found_ff <= 1'b1;
                     free_idx_ff   <= cmp_idx_ff;
                  end
                  if (cmp_status inside {SLOT_STAY, SLOT_NEW}) begin
                     active_ff <= active_ff + CNT_W'(1);
                  end
                  if (cmp_idx_ff == LAST_SLOT) begin
                     state_ff <= ST_DECIDE;
                  end
               end
            end

            ST_DECIDE: begin
               if (hit_found_ff && status_ff[hit_idx_ff] != SLOT_OLD) begin
                  run_ff <= run_in;
                  if (emit_go) begin
                     slot_ff     <= '0;
                     fresh_ff    <= 1'b0;
                     emit_cnt_ff <= '0;
                     state_ff    <= ST_EMIT;
                  end else begin
                     state_ff <= ST_IDLE;
                  end
               end else begin
                  state_ff <= ST_IDLE;
                  run_ff   <= '0;
                  if (hit_found_ff) begin
                     status_ff[hit_idx_ff] <= SLOT_STAY;
                  end else if (free_found_ff) begin
                     status_ff[free_idx_ff] <= SLOT_NEW;
                  end
               end
            end

            ST_EMIT: begin
               if (!emit_active || (fresh_ff && rsp_free)) begin
                  if (emit_active) begin
                     rsp_tag_ff   <= rd_data_ff;
                     rsp_last_ff  <= (emit_cnt_ff + CNT_W'(1) == active_ff);
                     emit_cnt_ff  <= emit_cnt_ff + CNT_W'(1);
                  end
                  fresh_ff <= 1'b0;
                  if (slot_ff == LAST_SLOT) begin
                     for (int i = 0; i < TABLE_SLOTS; i++) begin
                        case (status_ff[i])
                           SLOT_STAY, SLOT_NEW: status_ff[i] <= SLOT_OLD;
                           SLOT_OLD:            status_ff[i] <= SLOT_FREE;
                           default:             status_ff[i] <= SLOT_FREE;
                        endcase
                     end
                     state_ff <= ST_IDLE;
                  end else begin
                     slot_ff <= slot_ff + IDX_W'(1);
                  end
               end else begin
                  fresh_ff <= 1'b1;
               end
            end

            default: state_ff <= ST_IDLE;
         endcase
      end
   end

endmodule

### bench/tpst_checker.sv
// Checker that predicts the emitted tag lists from observed reads and register writes.
module tpst_checker
   import tpst_pkg::*;
#(
   parameter int TABLE_SLOTS = DEFAULT_SLOTS
) (
   input  logic                   clock,
   input  logic                   reset,
   tpst_req_if                    req_mon,
   tpst_rsp_if                    rsp_mon,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   output int                     fail_count,
   output int                     pending,
   output int                     read_count,
   output int                     tag_count,
   output int                     list_count,
   output int                     drop_count,
   output int                     saturated_count
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [TAG_LOW_W-1:0]  lo;
      logic [TAG_HIGH_W-1:0] hi;
      logic                  last;
   } emitted_tag_t;

   emitted_tag_t            expected_tags[$];
   slot_status_type         slot_state[TABLE_SLOTS];
   logic [TAG_LOW_W-1:0]    slot_low[TABLE_SLOTS];
   logic [TAG_HIGH_W-1:0]   slot_high[TABLE_SLOTS];
   logic [RUN_W-1:0]        stable_run;
   logic [STABLE_MIN_W-1:0] stable_min;
   logic [FACTOR_W-1:0]     stable_factor;

   function automatic bit slot_active(input slot_status_type s);
      return s == SLOT_STAY || s == SLOT_NEW;
   endfunction

   task automatic report_mismatch(input string what, input emitted_tag_t want,
                                  input emitted_tag_t got);
      fail_count++;
      if (fail_count <= 10)
         $display("mismatch at %0t: %s: expected lo=%h hi=%h last=%b, got lo=%h hi=%h last=%b",
                  $time, what, want.lo, want.hi, want.last, got.lo, got.hi, got.last);
   endtask

   function automatic void predict_read(input logic [TAG_LOW_W-1:0] lo,
                                        input logic [TAG_HIGH_W-1:0] hi);
      int           hit;
      int           free_slot;
      int           active;
      int           threshold;
      int           last_slot;
      int           i;
      bit           stable;
      emitted_tag_t item;

      hit       = -1;
      free_slot = -1;
      active    = 0;
      last_slot = -1;
      stable    = 1'b0;
      for (i = 0; i < TABLE_SLOTS; i++) begin
         if (hit < 0 && slot_state[i] != SLOT_FREE && slot_low[i] == lo && slot_high[i] == hi)
            hit = i;
         if (free_slot < 0 && slot_state[i] == SLOT_FREE)
            free_slot = i;
      end

      if (hit >= 0) begin
         if (slot_state[hit] == SLOT_OLD)
            slot_state[hit] = SLOT_STAY;
         else
            stable = 1'b1;
      end else if (free_slot >= 0) begin
         slot_low[free_slot]   = lo;
         slot_high[free_slot]  = hi;
         slot_state[free_slot] = SLOT_NEW;
      end else begin
         drop_count++;
      end

      if (!stable) begin
         stable_run = '0;
         return;
      end

      for (i = 0; i < TABLE_SLOTS; i++) begin
         if (slot_active(slot_state[i])) begin
            active++;
            last_slot = i;
         end
      end
      threshold = int'(stable_factor) * active;
      if (threshold < int'(stable_min))
         threshold = int'(stable_min);

      if (stable_run == RUN_MAX)
         saturated_count++;
      else
         stable_run++;
      if (int'(stable_run) <= threshold)
         return;

      list_count++;
      for (i = 0; i < TABLE_SLOTS; i++) begin
         if (slot_active(slot_state[i])) begin
            item.lo   = slot_low[i];
            item.hi   = slot_high[i];
            item.last = (i == last_slot);
            expected_tags.push_back(item);
         end
      end
      for (i = 0; i < TABLE_SLOTS; i++) begin
         if (slot_active(slot_state[i]))
            slot_state[i] = SLOT_OLD;
         else if (slot_state[i] == SLOT_OLD)
            slot_state[i] = SLOT_FREE;
      end
   endfunction

   always @(posedge clock) begin
      emitted_tag_t want;
      emitted_tag_t got;

      if (reset) begin
         expected_tags.delete();
         for (int i = 0; i < TABLE_SLOTS; i++) begin
            slot_state[i] = SLOT_FREE;
            slot_low[i]   = '0;
            slot_high[i]  = '0;
         end
         stable_run      = '0;
         stable_min      = STABLE_MIN_RESET;
         stable_factor   = FACTOR_RESET;
         fail_count      = 0;
         read_count      = 0;
         tag_count       = 0;
         list_count      = 0;
         drop_count      = 0;
         saturated_count = 0;
      end else begin
         if (csr_we) begin
            if (csr_index == CSR_STABLE_MIN)
               stable_min = csr_wdata[STABLE_MIN_W-1:0];
            else if (csr_index == CSR_STABLE_FACTOR)
               stable_factor = csr_wdata[FACTOR_W-1:0];
         end

         if (rsp_mon.valid && rsp_mon.ready) begin
            tag_count++;
            got.lo   = rsp_mon.out_tag_low;
            got.hi   = rsp_mon.out_tag_high;
            got.last = rsp_mon.last;
            if (expected_tags.size() == 0) begin
               report_mismatch("tag emitted with none expected", '0, got);
            end else begin
               want = expected_tags.pop_front();
               if (got.lo !== want.lo)
                  report_mismatch("out_tag_low differs", want, got);
               else if (got.hi !== want.hi)
                  report_mismatch("out_tag_high differs", want, got);
               else if (got.last !== want.last)
                  report_mismatch("last differs", want, got);
            end
         end

         if (req_mon.valid && req_mon.ready) begin
            read_count++;
            predict_read(req_mon.tag_low, req_mon.tag_high);
         end
      end
      pending = expected_tags.size();
   end

endmodule

### bench/tb.sv
// Testbench top: drives tag reads, register writes and result stalls, and gives the verdict.
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import tpst_pkg::*;

   localparam int SLOTS         = DEFAULT_SLOTS;
   localparam int SETTLE_CYCLES = 4 * SLOTS + 16;
   localparam int RANDOM_READS  = 80;
   localparam int RUN_LIMIT_NS  = 8_000_000;

   typedef logic [TAG_W-1:0] tag_type;

   logic                   clock;
   logic                   reset;
   logic                   csr_we;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;

   int fail_count;
   int pending;
   int read_count;
   int tag_count;
   int list_count;
   int drop_count;
   int saturated_count;

   int          burst_left;
   int          sent;
   int          cfg_min;
   int          cfg_factor;
   tag_type     pool[16];
   tag_type     prev_pool[16];
   int          prev_size;
   logic [15:0] stall_pattern;
   int          stall_left;

   tpst_req_if req_if ();
   tpst_rsp_if rsp_if ();

   tag_presence_stability_table_core #(.TABLE_SLOTS(SLOTS)) u_top (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_if),
      .rsp_ch    (rsp_if),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   tpst_checker #(.TABLE_SLOTS(SLOTS)) u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_mon         (req_if),
      .rsp_mon         (rsp_if),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .fail_count      (fail_count),
      .pending         (pending),
      .read_count      (read_count),
      .tag_count       (tag_count),
      .list_count      (list_count),
      .drop_count      (drop_count),
      .saturated_count (saturated_count)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #RUN_LIMIT_NS;
      $display("status: fail");
      $finish;
   end

   initial begin
      rsp_if.ready  = 1'b0;
      stall_pattern = '1;
      stall_left    = 0;
      forever begin
         @(negedge clock);
         if (stall_left == 0) begin
            stall_left = $urandom_range(30, 200);
            case ($urandom_range(0, 3))
               0: stall_pattern = '1;
               1: stall_pattern = 16'h0001;
               default: stall_pattern = 16'($urandom) | 16'h0001;
            endcase
         end
         stall_left--;
         stall_pattern = {stall_pattern[14:0], stall_pattern[15]};
         rsp_if.ready <= stall_pattern[0];
      end
   end

   function automatic tag_type random_tag();
      logic [127:0] r;
      r = {$urandom, $urandom, $urandom, $urandom};
      return r[TAG_W-1:0];
   endfunction

   function automatic int reads_to_emit(input int active);
      int t;
      t = cfg_factor * active;
      if (t < cfg_min)
         t = cfg_min;
      t += $urandom_range(1, 4);
      if (t > 90)
         t = 90;
      return t;
   endfunction

   task automatic send_tag(input tag_type tag);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         burst_left = $urandom_range(1, 12);
      end
      req_if.valid    <= 1'b1;
      req_if.tag_low  <= tag[TAG_LOW_W-1:0];
      req_if.tag_high <= tag[TAG_W-1:TAG_LOW_W];
      do @(posedge clock); while (!req_if.ready);
      @(negedge clock);
      burst_left--;
      sent++;
   endtask

   // drop valid and hold until the table is idle
   task automatic settle();
      req_if.valid <= 1'b0;
      burst_left = 0;
      while (pending != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_config(input int min_value, input int factor_value);
      logic [CSR_DATA_W-1:0] raw;
      raw = CSR_DATA_W'($urandom);
      raw[FACTOR_W-1:0] = factor_value[FACTOR_W-1:0];
      cfg_min    = min_value & 8'hFF;
      cfg_factor = factor_value & 3'h7;
      csr_we    <= 1'b1;
      csr_index <= CSR_STABLE_MIN;
      csr_wdata <= min_value[CSR_DATA_W-1:0];
      @(negedge clock);
      csr_index <= CSR_STABLE_FACTOR;
      csr_wdata <= raw;
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   initial begin
      tag_type tag_zero;
      tag_type tag_ones;
      tag_type tag_alt;
      tag_type fresh;
      int      kind;
      int      k;
      int      n;
      int      need;
      int      j;
      int      random_start;

      reset           = 1'b1;
      csr_we          = 1'b0;
      csr_index       = '0;
      csr_wdata       = '0;
      req_if.valid    = 1'b0;
      req_if.tag_low  = '0;
      req_if.tag_high = '0;
      burst_left      = 0;
      sent            = 0;
      prev_size       = 0;
      cfg_min         = STABLE_MIN_RESET;
      cfg_factor      = FACTOR_RESET;
      tag_zero        = '0;
      tag_ones        = '1;
      tag_alt         = {60{2'b10}};
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      settle();

      // threshold zero: every stable read emits the list
      write_config(0, 0);
      send_tag(tag_zero);
      send_tag(tag_ones);
      send_tag(tag_zero);
      send_tag(tag_ones);
      send_tag(tag_ones);
      // zero tag now sits in a freed slot and must come back as new
      send_tag(tag_zero);
      send_tag(tag_ones);
      send_tag(tag_zero);
      settle();

      write_config(0, 7);
      for (j = 0; j < 9; j++)
         send_tag(tag_alt);
      settle();

      // saturate the run count, then lower the minimum just under it
      write_config(255, 0);
      fresh = random_tag();
      for (j = 0; j < 260; j++)
         send_tag(fresh);
      settle();
      write_config(254, 0);
      send_tag(fresh);
      settle();

      random_start = sent;
      while (sent - random_start < RANDOM_READS) begin
         kind = $urandom_range(0, 9);
         if (kind == 9 || $urandom_range(0, 1) == 0) begin
            settle();
            if (kind == 9) begin
               write_config($urandom_range(0, 8), $urandom_range(0, 1));
            end else begin
               case ($urandom_range(0, 7))
                  0: n = 0;
                  1: n = 255;
                  default: n = $urandom_range(0, 20);
               endcase
               write_config(n, $urandom_range(0, 7));
            end
         end

         if (kind == 9) begin
            // overfill the table, then read back its earliest entries
            n = $urandom_range(SLOTS + 1, SLOTS + 8);
            for (j = 0; j < n; j++) begin
               fresh = random_tag();
               if (j < 4)
                  pool[j] = fresh;
               send_tag(fresh);
            end
            need = reads_to_emit(SLOTS);
            for (j = 0; j < need; j++)
               send_tag(pool[$urandom_range(0, 3)]);
            for (j = 0; j < 4; j++)
               prev_pool[j] = pool[j];
            prev_size = 4;
         end else if (kind == 8) begin
            n = $urandom_range(8, 16);
            for (j = 0; j < n; j++) begin
               if (prev_size > 0 && $urandom_range(0, 2) == 0)
                  send_tag(prev_pool[$urandom_range(0, prev_size - 1)]);
               else
                  send_tag(random_tag());
            end
         end else begin
            k = ($urandom_range(0, 4) == 0) ? $urandom_range(7, 12) : $urandom_range(1, 6);
            for (j = 0; j < k; j++) begin
               case ($urandom_range(0, 7))
                  0, 1: pool[j] = (prev_size > 0) ?
                                  prev_pool[$urandom_range(0, prev_size - 1)] : random_tag();
                  2: pool[j] = (j > 0) ?
                               pool[j-1] ^ (tag_type'(1) << $urandom_range(0, TAG_W - 1)) :
                               random_tag();
                  default: pool[j] = random_tag();
               endcase
               send_tag(pool[j]);
            end
            need = reads_to_emit(k);
            for (j = 0; j < need; j++) begin
               if ($urandom_range(0, 19) == 0)
                  send_tag(random_tag());
               else
                  send_tag(pool[$urandom_range(0, k - 1)]);
            end
            for (j = 0; j < k; j++)
               prev_pool[j] = pool[j];
            prev_size = k;
         end
      end

      settle();
      $display("run covered %0d tag reads, %0d dropped on a full table, %0d at a saturated count",
               read_count, drop_count, saturated_count);
      $display("run checked %0d emitted tags in %0d lists", tag_count, list_count);
      if (fail_count == 0 && pending == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule
